// ----- rtl/core/viau_pkg.sv -----
// ----------------------------------------------------------------------------
// viau_pkg: shared types and constants for the VM integer ALU
// Operation codes, data width and the pipeline beat type.
// ----------------------------------------------------------------------------
package viau_pkg;

  localparam int DataWidth = 32;
  localparam int KindWidth = 5;
  localparam int ShiftBits = 5;
  localparam int CntWidth  = $clog2(DataWidth + 1);

  typedef logic [DataWidth-1:0] word_t;
  typedef logic [KindWidth-1:0] kind_t;

  localparam kind_t OpAdd = 5'd0;
  localparam kind_t OpSub = 5'd1;
  localparam kind_t OpMul = 5'd2;
  localparam kind_t OpDiv = 5'd3;
  localparam kind_t OpMod = 5'd4;
  localparam kind_t OpAnd = 5'd5;
  localparam kind_t OpOr  = 5'd6;
  localparam kind_t OpXor = 5'd7;
  localparam kind_t OpNot = 5'd8;
  localparam kind_t OpInc = 5'd9;
  localparam kind_t OpDec = 5'd10;
  localparam kind_t OpShl = 5'd11;
  localparam kind_t OpShr = 5'd12;
  localparam kind_t OpMin = 5'd13;
  localparam kind_t OpMax = 5'd14;
  localparam kind_t OpEq  = 5'd15;
  localparam kind_t OpNe  = 5'd16;
  localparam kind_t OpLt  = 5'd17;
  localparam kind_t OpGt  = 5'd18;

  // Control carried alongside each beat through the divider pipeline
  typedef struct packed {
    logic  valid;
    logic  is_div;
    logic  is_mod;
    logic  q_neg;
    logic  zero;
    word_t simple;   // result of the combinational operations
  } div_ctl_t;

endpackage

// ----- rtl/core/viau_mul.sv -----
// ----------------------------------------------------------------------------
// viau_mul: pipelined wrapping multiplier
// Low half of a*b from 16-bit partial products, registered, then combined
// and delayed; the latency matches viau_div's so results line up.
// ----------------------------------------------------------------------------
module viau_mul (
  input  logic           clk,
  input  viau_pkg::word_t a,
  input  viau_pkg::word_t b,
  output viau_pkg::word_t prod
);
  import viau_pkg::*;

  localparam int Half = DataWidth / 2;
  localparam int Lat  = DataWidth;

  logic [Half-1:0] al, ah, bl, bh;
  word_t p_ll, p_lh, p_hl;
  word_t sum;
  word_t dly [Lat-1];

  assign al = a[Half-1:0];
  assign ah = a[DataWidth-1:Half];
  assign bl = b[Half-1:0];
  assign bh = b[DataWidth-1:Half];

  // Form partial products (low half only needed for cross terms)
  always_ff @(posedge clk) begin
    p_ll <= word_t'(al) * word_t'(bl);
    p_lh <= word_t'(al) * word_t'(bh);
    p_hl <= word_t'(ah) * word_t'(bl);
  end

  // Combine cross terms into the upper half
  always_ff @(posedge clk) begin
    sum <= p_ll + ((p_lh + p_hl) << Half);
  end

  // Delay to the divider's latency
  always_ff @(posedge clk) begin
    dly[0] <= sum;
    for (int i = 1; i < Lat - 1; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  assign prod = dly[Lat-2];
endmodule

// ----- rtl/core/viau_div.sv -----
// ----------------------------------------------------------------------------
// viau_div: pipelined restoring divider with result selection
// Unsigned magnitudes, one quotient bit per stage, then sign fix and final
// selection between quotient, remainder, product and the simple result.
// ----------------------------------------------------------------------------
module viau_div (
  input  logic                clk,
  input  logic                rst,
  input  viau_pkg::div_ctl_t  ctl_in,
  input  viau_pkg::word_t     a,
  input  viau_pkg::word_t     b,
  input  viau_pkg::word_t     prod,
  output logic                valid,
  output viau_pkg::word_t     value,
  output logic                err
);
  import viau_pkg::*;

  localparam int N = DataWidth;

  div_ctl_t ctl [N+1];
  word_t    rem [N+1];
  word_t    quo [N+1];
  word_t    dvs [N+1];

  word_t mag_a, mag_b;
  assign mag_a = a[N-1] ? word_t'(-a) : a;
  assign mag_b = b[N-1] ? word_t'(-b) : b;

  // Stage 0: take magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= ctl_in.valid;
    end
    ctl[0].is_div <= ctl_in.is_div;
    ctl[0].is_mod <= ctl_in.is_mod;
    ctl[0].q_neg  <= ctl_in.q_neg;
    ctl[0].zero   <= ctl_in.zero;
    ctl[0].simple <= ctl_in.simple;
    rem[0]        <= '0;
    quo[0]        <= mag_a;
    dvs[0]        <= mag_b;
  end

  // One quotient bit per stage
  for (genvar s = 0; s < N; s++) begin : g_step
    logic [N:0] trial;
    logic [N:0] shifted;
    assign shifted = {rem[s], quo[s][N-1]};
    assign trial   = shifted - {1'b0, dvs[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1].valid <= 1'b0;
      end else begin
        ctl[s+1].valid <= ctl[s].valid;
      end
      ctl[s+1].is_div <= ctl[s].is_div;
      ctl[s+1].is_mod <= ctl[s].is_mod;
      ctl[s+1].q_neg  <= ctl[s].q_neg;
      ctl[s+1].zero   <= ctl[s].zero;
      ctl[s+1].simple <= ctl[s].simple;
      dvs[s+1]        <= dvs[s];
      if (!trial[N]) begin
        rem[s+1] <= trial[N-1:0];
        quo[s+1] <= {quo[s][N-2:0], 1'b1};
      end else begin
        rem[s+1] <= shifted[N-1:0];
        quo[s+1] <= {quo[s][N-2:0], 1'b0};
      end
    end
  end

  // Multiply marker rides in q_neg when neither divide nor mod
  logic prod_sel;
  assign prod_sel = ctl[N].q_neg;

  // Final select: sign fix, zero divisor, simple result (multiply is picked below)
  word_t sel;
  always_comb begin
    if (ctl[N].is_div) begin
      if (ctl[N].zero) sel = '0;
      else sel = ctl[N].q_neg ? word_t'(-quo[N]) : quo[N];
    end else if (ctl[N].is_mod) begin
      sel = ctl[N].zero ? '0 : rem[N];
    end else begin
      sel = ctl[N].simple;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctl[N].valid;
    end
    value <= (ctl[N].simple == '0 && !ctl[N].is_div && !ctl[N].is_mod && prod_sel)
             ? prod : sel;
    err   <= (ctl[N].is_div || ctl[N].is_mod) && ctl[N].zero;
  end
endmodule

// ----- rtl/core/vm_integer_alu.sv -----
// ----------------------------------------------------------------------------
// vm_integer_alu: integer ALU of a bytecode virtual machine
// Add, sub, inc/dec, mul, div, absmod, logic, shifts, min/max and compares on two
// signed operands, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   | ports                               | marking
//  ----------+-------------------------------------+------------------
//  command   | kind, operand_a, operand_b          | start & !busy
//  result    | result_value, divide_error          | done (one cycle)
//
// One beat enters every cycle; busy is held low. Every operation travels
// through the one-bit-per-stage divider pipeline and its output register.
// Synchronous reset clears all valid bits. The receiver cannot stall, so
// no beat is ever held back.
module vm_integer_alu (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  viau_pkg::kind_t       kind,
  input  viau_pkg::word_t       operand_a,
  input  viau_pkg::word_t       operand_b,
  output logic                  done,
  output viau_pkg::word_t       result_value,
  output logic                  divide_error
);
  import viau_pkg::*;

  logic     a_lt_b, b_lt_a;
  logic [ShiftBits-1:0] sh;
  word_t    simple;
  div_ctl_t ctl;
  word_t    prod;

  assign busy   = 1'b0;
  assign a_lt_b = $signed(operand_a) < $signed(operand_b);
  assign b_lt_a = $signed(operand_b) < $signed(operand_a);
  assign sh     = operand_b[ShiftBits-1:0];

  // Combinational operations
  always_comb begin
    case (kind)
      OpAdd:   simple = operand_a + operand_b;
      OpSub:   simple = operand_a - operand_b;
      OpAnd:   simple = operand_a & operand_b;
      OpOr:    simple = operand_a | operand_b;
      OpXor:   simple = operand_a ^ operand_b;
      OpNot:   simple = ~operand_a;
      OpInc:   simple = operand_a + word_t'(1);
      OpDec:   simple = operand_a - word_t'(1);
      OpShl:   simple = (int'(sh) >= DataWidth) ? '0 : operand_a << sh;
      OpShr:   simple = (int'(sh) >= DataWidth) ? {DataWidth{operand_a[DataWidth-1]}}
                        : word_t'($signed(operand_a) >>> sh);
      OpMin:   simple = b_lt_a ? operand_b : operand_a;
      OpMax:   simple = a_lt_b ? operand_b : operand_a;
      OpEq:    simple = word_t'(operand_a == operand_b);
      OpNe:    simple = word_t'(operand_a != operand_b);
      OpLt:    simple = word_t'(a_lt_b);
      OpGt:    simple = word_t'(b_lt_a);
      default: simple = '0;
    endcase
  end

  // Build the beat control; multiply is flagged through q_neg
  always_comb begin
    ctl.valid  = start;
    ctl.is_div = (kind == OpDiv);
    ctl.is_mod = (kind == OpMod);
    ctl.zero   = (operand_b == '0);
    ctl.q_neg  = (kind == OpMul) ||
                 ((kind == OpDiv) && (operand_a[DataWidth-1] ^ operand_b[DataWidth-1]));
    ctl.simple = (kind == OpMul) ? '0 : simple;
  end

  viau_mul u_mul (
    .clk  (clk),
    .a    (operand_a),
    .b    (operand_b),
    .prod (prod)
  );

  viau_div u_div (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl),
    .a      (operand_a),
    .b      (operand_b),
    .prod   (prod),
    .valid  (done),
    .value  (result_value),
    .err    (divide_error)
  );
endmodule

// ----- rtl/core/viau_checker.sv -----
// ----------------------------------------------------------------------------
// viau_checker: port-level checks for vm_integer_alu
// Watches the result strobe and error flag against accepted commands, and busy.
// ----------------------------------------------------------------------------
module viau_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input viau_pkg::kind_t       kind,
  input viau_pkg::word_t       operand_b,
  input logic                  done,
  input viau_pkg::word_t       result_value,
  input logic                  divide_error
);
  import viau_pkg::*;

  localparam int Lat = DataWidth + 2;

  // Track accepted commands across the pipeline latency
  logic [Lat-1:0] acc;
  logic [Lat-1:0] zdiv;
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      zdiv <= '0;
    end else begin
      acc  <= {acc[Lat-2:0], start && !busy};
      zdiv <= {zdiv[Lat-2:0], start && !busy && operand_b == '0 &&
               (kind == OpDiv || kind == OpMod)};
    end
  end

  a_done_tracks: assert property (@(posedge clk) disable iff (rst)
    done == acc[Lat-1]) else $error("result strobe without matching command");

  a_err_tracks: assert property (@(posedge clk) disable iff (rst)
    done |-> (divide_error == zdiv[Lat-1])) else $error("divide error mismatch");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && divide_error) |-> (result_value == '0)) else $error("error result not zero");

  a_no_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule

bind vm_integer_alu viau_checker u_viau_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .kind         (kind),
  .operand_b    (operand_b),
  .done         (done),
  .result_value (result_value),
  .divide_error (divide_error)
);

// ----- test/tb_vm_integer_alu.sv -----
// ----------------------------------------------------------------------------
// tb_vm_integer_alu: self-checking testbench for the VM integer ALU
// Drives directed corner operations and then random commands under
// several sender idling phases, predicts each result and checks every
// done beat in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb_vm_integer_alu;
  timeunit 1ns;
  timeprecision 1ps;
  import viau_pkg::*;

  typedef struct packed {
    word_t value;
    logic  div_err;
  } alu_out_t;

  // Predicted results, oldest first, and the failure flag
  class alu_scoreboard;
    alu_out_t pending[$];
    bit       failed;

    function alu_out_t compute(kind_t op, word_t a, word_t b);
      alu_out_t   r;
      logic signed [DataWidth-1:0] sa, sb;
      word_t      ua, ub, q;
      int unsigned amt;
      sa = a;
      sb = b;
      ua = a[DataWidth-1] ? -a : a;
      ub = b[DataWidth-1] ? -b : b;
      amt = b[ShiftBits-1:0];
      r = '0;
      case (op)
        OpAdd: r.value = a + b;
        OpSub: r.value = a - b;
        OpMul: r.value = a * b;
        OpDiv: begin
          if (b == '0) r.div_err = 1'b1;
          else begin
            q = ua / ub;
            r.value = (a[DataWidth-1] ^ b[DataWidth-1]) ? -q : q;
          end
        end
        OpMod: begin
          if (b == '0) r.div_err = 1'b1;
          else r.value = ua % ub;
        end
        OpAnd: r.value = a & b;
        OpOr:  r.value = a | b;
        OpXor: r.value = a ^ b;
        OpNot: r.value = ~a;
        OpInc: r.value = a + 1;
        OpDec: r.value = a - 1;
        OpShl: r.value = (amt >= DataWidth) ? '0 : a << amt;
        OpShr: r.value = (amt >= DataWidth) ? {DataWidth{a[DataWidth-1]}} : word_t'(sa >>> amt);
        OpMin: r.value = (sb < sa) ? b : a;
        OpMax: r.value = (sa < sb) ? b : a;
        OpEq:  r.value = word_t'(a == b);
        OpNe:  r.value = word_t'(a != b);
        OpLt:  r.value = word_t'(sa < sb);
        OpGt:  r.value = word_t'(sb < sa);
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_command(kind_t op, word_t a, word_t b);
      pending.push_back(compute(op, a, b));
    endfunction

    function void check_result(word_t value, logic div_err);
      alu_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result value=%h divide_error=%b", value, div_err);
        failed = 1;
        return;
      end
      e = pending.pop_front();
      if (value !== e.value) begin
        $error("result_value: expected %h, actual %h", e.value, value);
        failed = 1;
      end
      if (div_err !== e.div_err) begin
        $error("divide_error: expected %b, actual %b", e.div_err, div_err);
        failed = 1;
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  kind_t kind = '0;
  word_t operand_a = '0;
  word_t operand_b = '0;
  logic  done;
  word_t result_value;
  logic  divide_error;
  int    idle_pct = 0;
  alu_scoreboard sb = new();

  vm_integer_alu dut (
    .clk, .rst, .start, .busy, .kind, .operand_a, .operand_b,
    .done, .result_value, .divide_error
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Note accepted commands and check results at each rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_command(kind, operand_a, operand_b);
      if (done) sb.check_result(result_value, divide_error);
    end
  end

  // Issue one command beat, with random idle cycles before it
  task automatic send_cmd(kind_t op, word_t a, word_t b);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Pick an operand biased toward corner values
  function automatic word_t pick_operand();
    case ($urandom_range(7, 0))
      0: return {1'b1, {(DataWidth-1){1'b0}}};
      1: return {1'b0, {(DataWidth-1){1'b1}}};
      2: return word_t'($urandom_range(2, 0)) - 1;
      3: return word_t'($urandom_range(40, 0));
      4: return word_t'($urandom_range(65535, 0)) - 32768;
      default: return word_t'($urandom());
    endcase
  endfunction

  initial begin
    word_t min_v, max_v;
    kind_t op;
    min_v = {1'b1, {(DataWidth-1){1'b0}}};
    max_v = ~min_v;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: zero divisors, min over -1, shift range, unused codes
    send_cmd(OpDiv, 32'd7, '0);
    send_cmd(OpMod, min_v, '0);
    send_cmd(OpDiv, min_v, '1);
    send_cmd(OpMod, min_v, '1);
    send_cmd(OpDiv, -32'sd7, 32'd2);
    send_cmd(OpMod, -32'sd7, 32'd2);
    send_cmd(OpMod, 32'd7, -32'sd2);
    send_cmd(OpAdd, max_v, 32'd1);
    send_cmd(OpSub, min_v, 32'd1);
    send_cmd(OpMul, max_v, max_v);
    send_cmd(OpShl, 32'd1, 32'd31);
    send_cmd(OpShl, '1, 32'hFFFF_FFE1);
    send_cmd(OpShr, min_v, 32'd31);
    send_cmd(OpShr, min_v, 32'd32);
    send_cmd(OpNot, '0, '1);
    send_cmd(OpInc, max_v, min_v);
    send_cmd(OpDec, min_v, max_v);
    send_cmd(OpMin, min_v, max_v);
    send_cmd(OpMax, min_v, max_v);
    send_cmd(OpEq, '1, '1);
    send_cmd(OpNe, '1, '0);
    send_cmd(OpLt, min_v, max_v);
    send_cmd(OpGt, min_v, max_v);
    send_cmd(kind_t'(19), '1, '1);
    send_cmd(kind_t'(31), '1, '1);

    // Random phases: no idling, then mostly idle, then partly idle, then no idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 65 : (ph == 2) ? 34 : 0;
      for (int i = 0; i < 345; i++) begin
        op = ($urandom_range(19, 0) == 0) ? kind_t'($urandom_range(31, 19))
                                          : kind_t'($urandom_range(18, 0));
        send_cmd(op, pick_operand(), pick_operand());
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then wait out the pipeline
    for (int w = 0; w < 2000 && sb.pending.size() != 0; w++) @(posedge clk);
    repeat (DataWidth + 10) @(posedge clk);
    if (sb.failed || sb.pending.size() != 0) $display("== FAIL ==");
    else $display("== PASS ==");
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/viau_pkg.sv
rtl/core/viau_mul.sv
rtl/core/viau_div.sv
rtl/core/vm_integer_alu.sv
rtl/core/viau_checker.sv
test/tb_vm_integer_alu.sv
